@@ hw/rtl/sos_pkg.sv @@
// Shared types and constants for the set-of-stacks block.
// Holds the transfer structs, action and status codes, and the internal command format.
// No dependencies.
package sos_pkg;

    localparam int CFG_W         = 5;
    localparam int PLATES_RESET  = 10;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_POPAT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_PEEK = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] push_value;
        logic [6:0]         sub_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
        logic               all_empty;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK,
        OP_POPAT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic [6:0]         idx;
        logic               idx_ok;
    } t_cmd;

endpackage

@@ hw/rtl/sos_front.sv @@
// Front end of the set-of-stacks block: accepts items, decodes them into commands,
// and holds them in a two-entry queue for the back end. Depends on sos_pkg.
module sos_front
    import sos_pkg::*;
#(
    parameter int NUM_STACKS = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    input  logic     i_busy,
    input  logic     i_take,
    output logic     o_q_valid,
    output t_cmd     o_q_head
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       dec;
    logic       wr;
    logic       rd;

    always_comb begin
        dec.value  = i_in_item.push_value;
        dec.idx    = i_in_item.sub_index;
        dec.idx_ok = int'(i_in_item.sub_index) < NUM_STACKS;
        case (i_in_item.action)
            ACT_PUSH:  dec.op = OP_PUSH;
            ACT_POP:   dec.op = OP_POP;
            ACT_PEEK:  dec.op = OP_PEEK;
            ACT_POPAT: dec.op = OP_POPAT;
            default:   dec.op = OP_POPAT;
        endcase
    end

    assign full      = (r_count == 2'd2) || i_busy;
    assign wr        = push && !full;
    assign o_q_valid = (r_count != 2'd0);
    assign rd        = i_take && o_q_valid;
    assign o_q_head  = r_q[r_rp];

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 2'd1;
        end else if (rd && !wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

@@ hw/rtl/sos_back.sv @@
// Back end of the set-of-stacks block: a sequencer over the fill-count and plate memories
// that executes one command at a time and holds the result register. Depends on sos_pkg.
module sos_back
    import sos_pkg::*;
#(
    parameter int NUM_STACKS  = 128,
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_q_valid,
    input  t_cmd             i_q_head,
    output logic             o_take,
    output logic             o_busy,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_out_item
);

    localparam int SW = $clog2(NUM_STACKS);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam logic [SW-1:0] LAST      = SW'(NUM_STACKS - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] THR_RESET =
        CW'((PLATES_RESET > STACK_DEPTH) ? STACK_DEPTH : PLATES_RESET);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_NEXT,
        S_DATA
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] n_cur;
    logic [SW-1:0] r_clr;
    t_cmd        r_cmd;
    logic [CW-1:0] r_thr;
    logic [CW-1:0] thr_new;
    logic [CW-1:0] r_fill0;
    logic [CW-1:0] n_fill0;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [CW-1:0] r_fill [NUM_STACKS];
    logic [CW-1:0] r_cnt_rd;
    logic [SW-1:0] cnt_ra;
    logic        cnt_we;
    logic [SW-1:0] cnt_wa;
    logic [CW-1:0] cnt_wd;

    logic [31:0] r_plate [NUM_STACKS * STACK_DEPTH];
    logic [31:0] r_pl_rd;
    logic [AW-1:0] pl_ra;
    logic        pl_we;
    logic [AW-1:0] pl_wa;
    logic [31:0] pl_wd;

    logic        fin;
    logic signed [31:0] fin_top;
    logic [1:0]  fin_status;

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                 input logic [CW-1:0] p);
        slot_addr = AW'(s) * AW'(STACK_DEPTH) + AW'(p);
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            thr_new = CW'(1);
        end else if (int'(i_cfg_data) > STACK_DEPTH) begin
            thr_new = DEPTH_C;
        end else begin
            thr_new = CW'(i_cfg_data);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        o_take     = 1'b0;
        cnt_ra     = r_cur;
        cnt_we     = 1'b0;
        cnt_wa     = r_cur;
        cnt_wd     = r_cnt_rd;
        pl_ra      = slot_addr(r_cur, r_cnt_rd - CW'(1));
        pl_we      = 1'b0;
        pl_wa      = slot_addr(r_cur, r_cnt_rd);
        pl_wd      = r_cmd.value;
        fin        = 1'b0;
        fin_top    = '0;
        fin_status = ST_OK;
        case (r_state)
            S_CLEAR: begin
                cnt_we = 1'b1;
                cnt_wa = r_clr;
                cnt_wd = '0;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && (!r_out_valid || pop)) begin
                    o_take  = 1'b1;
                    n_state = S_CNT;
                    if (i_q_head.op == OP_POPAT) begin
                        cnt_ra = SW'(i_q_head.idx);
                    end
                end
            end
            S_CNT: begin
                case (r_cmd.op)
                    OP_PUSH: begin
                        if (r_cnt_rd >= r_thr) begin
                            if (r_cur == LAST) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                cnt_ra  = r_cur + SW'(1);
                                n_state = S_NEXT;
                            end
                        end else begin
                            cnt_we = 1'b1;
                            cnt_wd = r_cnt_rd + CW'(1);
                            pl_we  = 1'b1;
                            fin    = 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (r_cnt_rd == '0) begin
                            if (r_cur == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                                if (r_cmd.op == OP_PEEK) begin
                                    fin_top = EMPTY_PEEK;
                                end
                            end else begin
                                n_cur   = r_cur - SW'(1);
                                cnt_ra  = r_cur - SW'(1);
                                n_state = S_NEXT;
                            end
                        end else if (r_cmd.op == OP_POP) begin
                            cnt_we = 1'b1;
                            cnt_wd = r_cnt_rd - CW'(1);
                            fin    = 1'b1;
                        end else begin
                            n_state = S_DATA;
                        end
                    end
                    default: begin
                        if (!r_cmd.idx_ok || r_cnt_rd == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            cnt_we = 1'b1;
                            cnt_wa = SW'(r_cmd.idx);
                            cnt_wd = r_cnt_rd - CW'(1);
                            fin    = 1'b1;
                        end
                    end
                endcase
            end
            S_NEXT: begin
                if (r_cmd.op == OP_PUSH) begin
                    if (r_cnt_rd >= DEPTH_C) begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                    end else begin
                        n_cur  = r_cur + SW'(1);
                        cnt_we = 1'b1;
                        cnt_wa = r_cur + SW'(1);
                        cnt_wd = r_cnt_rd + CW'(1);
                        pl_we  = 1'b1;
                        pl_wa  = slot_addr(r_cur + SW'(1), r_cnt_rd);
                        fin    = 1'b1;
                    end
                end else if (r_cnt_rd == '0) begin
                    fin        = 1'b1;
                    fin_status = ST_EMPTY;
                    if (r_cmd.op == OP_PEEK) begin
                        fin_top = EMPTY_PEEK;
                    end
                end else if (r_cmd.op == OP_POP) begin
                    cnt_we = 1'b1;
                    cnt_wd = r_cnt_rd - CW'(1);
                    fin    = 1'b1;
                end else begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                fin     = 1'b1;
                fin_top = r_pl_rd;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = S_IDLE;
        end
    end

    assign n_fill0 = (cnt_we && cnt_wa == '0) ? cnt_wd : r_fill0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_clr       <= '0;
            r_thr       <= THR_RESET;
            r_fill0     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_fill0 <= n_fill0;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cfg_we) begin
                r_thr <= thr_new;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_cmd <= i_q_head;
        end
        if (fin) begin
            r_out.top_value <= fin_top;
            r_out.status    <= fin_status;
            r_out.all_empty <= (n_cur == '0) && (n_fill0 == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_fill[cnt_wa] <= cnt_wd;
        end
        r_cnt_rd <= r_fill[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_plate[pl_wa] <= pl_wd;
        end
        r_pl_rd <= r_plate[pl_ra];
    end

    assign o_busy     = (r_state == S_CLEAR);
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    a_fin_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_out_valid)
        else $error("result produced while result register occupied");

    a_data_peek_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_cmd.op == OP_PEEK))
        else $error("plate read finished for a command other than peek");

    a_full_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && fin_status == ST_FULL) |-> (r_cmd.op == OP_PUSH))
        else $error("full status reported for a command other than push");

    a_plate_write_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pl_we |-> (cnt_we && r_cmd.op == OP_PUSH && r_state != S_CLEAR))
        else $error("plate write without matching push count update");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_state == S_CNT))
        else $error("command taken but sequencer did not start");

endmodule

@@ hw/rtl/set_of_stacks.sv @@
// Top level of the set-of-stacks block: one logical stack built from NUM_STACKS sub-stacks.
// Instantiates sos_front and sos_back. Depends on sos_pkg.
//
// Usage: items are written through a queue-like port. An item transfers at a clock edge
// where push is high and full is low. Results leave through a second queue-like port:
// the oldest result is on o_out_item while empty is low and transfers when pop is high.
// Every item gives exactly one result, in order. The user must write the threshold register
// through i_cfg_we and i_cfg_data while the block holds no work in flight (unchecked).
//
// Sequence: a push that stays in its sub-stack, a pop that finds data in the current
// sub-stack, and any pop-at finish in S_CNT; a push that moves on and a pop that steps
// back go on to S_NEXT; a plain peek goes on to S_DATA; a peek that steps back passes
// through S_NEXT and then S_DATA. The sequencer reads the fill-count memory once per
// step and the plate memory once more for a peek; one item is done before the next starts.
// A two-entry command queue lets the input side keep taking items while the sequencer
// works or while a result waits to be popped; once it is full, full stays high.
// Reset: after i_rst_n is released, the fill counts are cleared one sub-stack per cycle,
// for all NUM_STACKS sub-stacks, with full held high. The threshold returns to 10.
module set_of_stacks
    import sos_pkg::*;
#(
    parameter int NUM_STACKS  = 128,
    parameter int STACK_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_in_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_out_item
);

    logic q_valid;
    t_cmd q_head;
    logic take;
    logic busy;

    sos_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_busy    (busy),
        .i_take    (take),
        .o_q_valid (q_valid),
        .o_q_head  (q_head)
    );

    sos_back #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_head   (q_head),
        .o_take     (take),
        .o_busy     (busy),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

endmodule
